[src/h264fu_pkg.sv]
// ----------------------------------------------------------------------------
// h264fu_pkg
// Shared types, constants and helpers of the H.264 RTP FU-A packetizer.
// ----------------------------------------------------------------------------
`default_nettype none

package h264fu_pkg;

  localparam int NAL_LEN_W     = 16;
  localparam int PAY_W         = 13;
  localparam int SEQ_W         = 16;
  localparam int TS_W          = 32;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 32;
  localparam int MAX_NAL_BYTES_DEF = 65535;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TS_STEP     = 1'd1;

  localparam logic [PAY_W-1:0] MAX_PAYLOAD_RST = 13'd1400;
  localparam logic [TS_W-1:0]  TS_STEP_RST     = 32'd3600;
  localparam logic [PAY_W-1:0] PAYLOAD_MIN     = 13'd3;
  localparam logic [PAY_W-1:0] PAYLOAD_MAX     = 13'd4096;

  localparam logic [7:0] NAL_TYPE_MASK = 8'h1F;
  localparam logic [7:0] NAL_FNRI_MASK = 8'hE0;
  localparam logic [7:0] FU_A_TYPE     = 8'd28;
  localparam logic [7:0] FU_S_BIT      = 8'h80;
  localparam logic [7:0] FU_E_BIT      = 8'h40;
  localparam logic [7:0] NAL_TYPE_SPS  = 8'd7;
  localparam logic [7:0] NAL_TYPE_PPS  = 8'd8;

  typedef struct packed {
    logic             frag_mode;
    logic [7:0]       held_hdr;
    logic [PAY_W-1:0] fill;
    logic             first_frag;
    logic [SEQ_W-1:0] seq;
    logic [TS_W-1:0]  ts;
  } state_t;

  // up to three payload bytes caused by one input byte
  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
    logic            first;   // packet start on bytes[0]
    logic            final_b; // packet end on the last byte
  } res_t;

  function automatic logic is_param_set(input logic [7:0] hdr);
    logic [7:0] t;
    t = hdr & NAL_TYPE_MASK;
    return (t == NAL_TYPE_SPS) || (t == NAL_TYPE_PPS);
  endfunction

endpackage

`default_nettype wire

[src/h264_rtp_fu_a_packetizer.sv]
// ----------------------------------------------------------------------------
// h264_rtp_fu_a_packetizer
// RFC 6184 packetizer: single NAL unit packets and FU-A fragmentation.
// ----------------------------------------------------------------------------
// Feed one NAL unit byte per cycle while in_tready is high, header byte first
// with in_tuser high and the NAL length in in_tdata. Ordinary bytes pass
// straight through; the header byte of a NAL that needs fragmenting is absorbed
// with no output; the first body byte of each FU-A fragment puts three bytes
// out (FU indicator, FU header, byte), during which in_tready drops. The
// three-entry result register drains one byte per cycle while out_tready is
// high and takes the next input in the cycle its last entry leaves. Sequence
// number and timestamp ride with every payload byte.
`default_nettype none

module h264_rtp_fu_a_packetizer #(
  parameter int MAX_NAL_BYTES = h264fu_pkg::MAX_NAL_BYTES_DEF
) (
  input  wire  logic                                 clk,
  input  wire  logic                                 rst_n,
  input  wire  logic                                 in_tvalid,
  output logic                                       in_tready,
  input  wire  logic [23:0]                          in_tdata,  // data_byte, nal_length
  input  wire  logic                                 in_tuser,  // nal_start
  output logic                                       out_tvalid,
  input  wire  logic                                 out_tready,
  output logic [55:0]                                out_tdata, // payload_byte, sequence_out,
                                                                // timestamp_out
  output logic [1:0]                                 out_tuser, // packet_first, last_of_item
  output logic                                       out_tlast, // packet_final
  input  wire  logic                                 cfg_we,
  input  wire  logic [h264fu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  logic [h264fu_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int BL_W = ($clog2(MAX_NAL_BYTES) < h264fu_pkg::NAL_LEN_W) ?
                        $clog2(MAX_NAL_BYTES) : h264fu_pkg::NAL_LEN_W;

  logic [h264fu_pkg::PAY_W-1:0] max_pl_r;
  logic [h264fu_pkg::TS_W-1:0]  ts_step_r;
  logic [h264fu_pkg::PAY_W-1:0] max_eff;

  h264fu_pkg::state_t st_r, st_nxt;
  logic [BL_W-1:0]    bl_r, bl_nxt;
  h264fu_pkg::res_t   res;

  logic [1:0]                   ob_cnt_r;
  logic [2:0][7:0]              ob_bytes_r;
  logic                         ob_first_r;
  logic                         ob_final_r;
  logic [h264fu_pkg::SEQ_W-1:0] ob_seq_r;
  logic [h264fu_pkg::TS_W-1:0]  ob_ts_r;

  logic take, in_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_pl_r  <= h264fu_pkg::MAX_PAYLOAD_RST;
      ts_step_r <= h264fu_pkg::TS_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        h264fu_pkg::REG_MAX_PAYLOAD: max_pl_r  <= cfg_data[h264fu_pkg::PAY_W-1:0];
        h264fu_pkg::REG_TS_STEP:     ts_step_r <= cfg_data[h264fu_pkg::TS_W-1:0];
        default: ;
      endcase
    end
  end

  assign max_eff = (max_pl_r < h264fu_pkg::PAYLOAD_MIN) ? h264fu_pkg::PAYLOAD_MIN :
                   (max_pl_r > h264fu_pkg::PAYLOAD_MAX) ? h264fu_pkg::PAYLOAD_MAX :
                   max_pl_r;

  h264fu_step #(
    .MAX_NAL_BYTES (MAX_NAL_BYTES)
  ) u_step (
    .st         (st_r),
    .bl         (bl_r),
    .data_byte  (in_tdata[7:0]),
    .nal_start  (in_tuser),
    .nal_length (in_tdata[23:8]),
    .max_pl     (max_eff),
    .ts_step    (ts_step_r),
    .st_nxt     (st_nxt),
    .bl_nxt     (bl_nxt),
    .res        (res)
  );

  assign out_tvalid = (ob_cnt_r != 2'd0);
  assign take       = out_tvalid && out_tready;
  assign in_tready  = (ob_cnt_r == 2'd0) || (take && (ob_cnt_r == 2'd1));
  assign in_fire    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= '0;
      bl_r     <= '0;
      ob_cnt_r <= 2'd0;
    end else begin
      if (in_fire) begin
        st_r <= st_nxt;
        bl_r <= bl_nxt;
      end
      if (in_fire && (res.cnt != 2'd0)) begin
        ob_cnt_r <= res.cnt;
      end else if (take) begin
        ob_cnt_r <= ob_cnt_r - 2'd1;
      end
    end
  end

  // payload side, no reset needed; the count qualifies it
  always_ff @(posedge clk) begin
    if (in_fire && (res.cnt != 2'd0)) begin
      // three-byte group loads in emit order; a single byte goes to entry 0
      ob_bytes_r <= (res.cnt == 2'd3) ? res.bytes : {res.bytes[2:1], res.bytes[0]};
      ob_first_r <= res.first;
      ob_final_r <= res.final_b;
      ob_seq_r   <= st_r.seq;
      ob_ts_r    <= st_r.ts;
    end else if (take) begin
      ob_bytes_r <= {8'h00, ob_bytes_r[2:1]};
      ob_first_r <= 1'b0;
    end
  end

  assign out_tdata = {ob_ts_r, ob_seq_r, ob_bytes_r[0]};
  assign out_tuser = {(ob_cnt_r == 2'd1), ob_first_r};
  assign out_tlast = ob_final_r && (ob_cnt_r == 2'd1);

endmodule

`default_nettype wire

[src/h264fu_step.sv]
// ----------------------------------------------------------------------------
// h264fu_step
// Per-byte packetizing decision: next state and the payload bytes to emit.
// ----------------------------------------------------------------------------
`default_nettype none

module h264fu_step #(
  parameter  int MAX_NAL_BYTES = h264fu_pkg::MAX_NAL_BYTES_DEF,
  localparam int BL_W = ($clog2(MAX_NAL_BYTES) < h264fu_pkg::NAL_LEN_W) ?
                        $clog2(MAX_NAL_BYTES) : h264fu_pkg::NAL_LEN_W
) (
  input  wire  h264fu_pkg::state_t                     st,
  input  wire  logic [BL_W-1:0]                        bl,
  input  wire  logic [7:0]                             data_byte,
  input  wire  logic                                   nal_start,
  input  wire  logic [h264fu_pkg::NAL_LEN_W-1:0]       nal_length,
  input  wire  logic [h264fu_pkg::PAY_W-1:0]           max_pl,
  input  wire  logic [h264fu_pkg::TS_W-1:0]            ts_step,
  output h264fu_pkg::state_t                           st_nxt,
  output logic [BL_W-1:0]                              bl_nxt,
  output h264fu_pkg::res_t                             res
);

  logic [h264fu_pkg::NAL_LEN_W-1:0] len_nz;
  logic [h264fu_pkg::NAL_LEN_W-1:0] total;
  logic                             fits;
  logic [BL_W-1:0]                  bl_dec;
  logic                             bl_last;
  logic [h264fu_pkg::PAY_W-1:0]     fill_inc;
  logic                             frag_last;
  logic [7:0]                       fu_ind;
  logic [7:0]                       fu_hdr;
  logic                             close_pkt;
  logic                             adv_time;

  assign len_nz = (nal_length == '0) ? h264fu_pkg::NAL_LEN_W'(1) : nal_length;
  assign total  = (32'(len_nz) > 32'(MAX_NAL_BYTES)) ?
                  h264fu_pkg::NAL_LEN_W'(MAX_NAL_BYTES) : len_nz;
  assign fits   = total <= h264fu_pkg::NAL_LEN_W'(max_pl);

  assign bl_dec    = bl - BL_W'(1);
  assign bl_last   = (bl_dec == '0);
  assign fill_inc  = st.fill + h264fu_pkg::PAY_W'(1);
  assign frag_last = bl_last || (fill_inc >= max_pl);

  assign fu_ind = (st.held_hdr & h264fu_pkg::NAL_FNRI_MASK) | h264fu_pkg::FU_A_TYPE;
  assign fu_hdr = (st.held_hdr & h264fu_pkg::NAL_TYPE_MASK)
                | (st.first_frag ? h264fu_pkg::FU_S_BIT : 8'h00)
                | ((h264fu_pkg::NAL_LEN_W'(bl) <= h264fu_pkg::NAL_LEN_W'(max_pl)) ?
                   h264fu_pkg::FU_E_BIT : 8'h00);

  always_comb begin
    st_nxt    = st;
    bl_nxt    = bl;
    res       = '0;
    close_pkt = 1'b0;
    adv_time  = 1'b0;
    if (nal_start) begin
      st_nxt.held_hdr = data_byte;
      st_nxt.fill     = '0;
      bl_nxt          = BL_W'(total - h264fu_pkg::NAL_LEN_W'(1));
      if (fits) begin
        st_nxt.frag_mode  = 1'b0;
        st_nxt.first_frag = 1'b0;
        res.cnt           = 2'd1;
        res.bytes[0]      = data_byte;
        res.first         = 1'b1;
        res.final_b       = (total == h264fu_pkg::NAL_LEN_W'(1));
        close_pkt         = res.final_b;
        adv_time          = res.final_b && !h264fu_pkg::is_param_set(data_byte);
      end else begin
        // header is held back, nothing goes out yet
        st_nxt.frag_mode  = 1'b1;
        st_nxt.first_frag = 1'b1;
      end
    end else if (bl != '0) begin
      bl_nxt = bl_dec;
      if (!st.frag_mode) begin
        res.cnt      = 2'd1;
        res.bytes[0] = data_byte;
        res.final_b  = bl_last;
        close_pkt    = bl_last;
        adv_time     = bl_last && !h264fu_pkg::is_param_set(st.held_hdr);
      end else begin
        if (st.fill == '0) begin
          res.cnt           = 2'd3;
          res.bytes[0]      = fu_ind;
          res.bytes[1]      = fu_hdr;
          res.bytes[2]      = data_byte;
          res.first         = 1'b1;
          st_nxt.first_frag = 1'b0;
        end else begin
          res.cnt      = 2'd1;
          res.bytes[0] = data_byte;
        end
        res.final_b = frag_last;
        st_nxt.fill = frag_last ? '0 : fill_inc;
        close_pkt   = frag_last;
        if (bl_last) begin
          st_nxt.frag_mode = 1'b0;
          adv_time         = 1'b1;
        end
      end
    end
    if (close_pkt) begin
      st_nxt.seq = st.seq + h264fu_pkg::SEQ_W'(1);
    end
    if (adv_time) begin
      st_nxt.ts = st.ts + ts_step;
    end
  end

endmodule

`default_nettype wire

[src/h264fu_chk.sv]
// ----------------------------------------------------------------------------
// h264fu_chk
// Port-level checks of the packetizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module h264fu_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata,
  input wire logic [1:0]  out_tuser,
  input wire logic        out_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // packet end is always the last byte of its input group
  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[1])
    else $error("packet end before end of group");

  // the rest of a group follows without a gap
  a_group_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tuser[1] |=> out_tvalid)
    else $error("group broken off");

  // bytes of one group share sequence number and timestamp
  a_group_tags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tuser[1] |=>
      out_tdata[55:8] == $past(out_tdata[55:8]))
    else $error("tags changed within group");

endmodule

bind h264_rtp_fu_a_packetizer h264fu_chk u_h264fu_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire

[dv/h264_rtp_fu_a_packetizer_test.sv]
// ----------------------------------------------------------------------------
// h264_rtp_fu_a_packetizer_test
// Self-checking bench for the RTP FU-A packetizer. A directed table covers
// reset values, length and data extremes, parameter-set NALs, stray bytes,
// abandoned NALs and payload size changes inside a NAL. Random phases follow,
// with fresh register settings each. Every output byte is scored, against the
// inline expectation of a typed directed row or else a behavioral packetizer,
// under bursty or smooth input and an open or stalling output.
module h264_rtp_fu_a_packetizer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NAL_CAP = h264fu_pkg::MAX_NAL_BYTES_DEF;

  typedef struct packed {
    logic [7:0]                   pay;
    logic                         first;
    logic                         fin;
    logic [h264fu_pkg::SEQ_W-1:0] seq;
    logic [h264fu_pkg::TS_W-1:0]  ts;
    logic                         last;
  } pkt_byte_t;

  // one input request; typed rows carry their expected output inline
  typedef struct packed {
    logic [7:0]                       d;
    logic                             st;
    logic [h264fu_pkg::NAL_LEN_W-1:0] len;
    logic                             typed;
    logic                             tcnt;
    pkt_byte_t                        want;
  } nal_req_t;

  typedef struct packed {
    logic                              is_cfg;
    logic [h264fu_pkg::CFG_IDX_W-1:0]  idx;
    logic [h264fu_pkg::CFG_DATA_W-1:0] val;
    nal_req_t                          req;
  } dir_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_RUNS} rx_mode_t;

  logic                              clk        = 1'b0;
  logic                              rst_n      = 1'b0;
  logic                              in_tvalid  = 1'b0;
  logic                              in_tready;
  logic [23:0]                       in_tdata   = '0;  // data_byte, nal_length
  logic                              in_tuser   = 1'b0; // nal_start
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [55:0]                       out_tdata;   // payload_byte, sequence_out, timestamp_out
  logic [1:0]                        out_tuser;   // packet_first, last_of_item
  logic                              out_tlast;   // packet_final
  logic                              cfg_we     = 1'b0;
  logic [h264fu_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [h264fu_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

  h264_rtp_fu_a_packetizer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------- packetizer
  logic [h264fu_pkg::PAY_W-1:0]     max_pay;
  logic [h264fu_pkg::TS_W-1:0]      ts_step;
  logic                             in_frag;
  logic [7:0]                       held;
  logic [h264fu_pkg::NAL_LEN_W-1:0] left_cnt;
  logic [h264fu_pkg::PAY_W-1:0]     fill_cnt;
  logic                             first_frag;
  logic [h264fu_pkg::SEQ_W-1:0]     seq_no;
  logic [h264fu_pkg::TS_W-1:0]      ts_now;

  pkt_byte_t fresh_q[$];
  pkt_byte_t pkt_byte_q[$];
  nal_req_t  cur_req = '0;
  int        mismatches = 0;

  function automatic void emit(input logic [7:0] b, input logic first, input logic fin);
    fresh_q.push_back('{b, first, fin, seq_no, ts_now, 1'b0});
  endfunction

  // single-packet NAL done: SPS and PPS share the timestamp of what follows
  function automatic void close_single(input logic [7:0] hdr);
    logic [7:0] kind;
    kind   = hdr & h264fu_pkg::NAL_TYPE_MASK;
    seq_no = seq_no + 1'b1;
    if (kind != h264fu_pkg::NAL_TYPE_SPS && kind != h264fu_pkg::NAL_TYPE_PPS)
      ts_now = ts_now + ts_step;
  endfunction

  task automatic packetize_byte(input logic [7:0] d, input logic st,
                                input logic [h264fu_pkg::NAL_LEN_W-1:0] len);
    int         eff;
    int         total;
    logic [7:0] fu;
    logic       close;
    pkt_byte_t  tail;
    eff = int'(max_pay);
    if (eff < int'(h264fu_pkg::PAYLOAD_MIN)) eff = int'(h264fu_pkg::PAYLOAD_MIN);
    if (eff > int'(h264fu_pkg::PAYLOAD_MAX)) eff = int'(h264fu_pkg::PAYLOAD_MAX);
    fresh_q.delete();
    if (st) begin
      total = (len == '0) ? 1 : int'(len);
      if (total > NAL_CAP) total = NAL_CAP;
      held     = d;
      fill_cnt = '0;
      left_cnt = h264fu_pkg::NAL_LEN_W'(total - 1);
      if (total <= eff) begin
        in_frag    = 1'b0;
        first_frag = 1'b0;
        emit(d, 1'b1, total == 1);
        if (total == 1) close_single(d);
      end else begin
        in_frag    = 1'b1;
        first_frag = 1'b1;
      end
    end else if (left_cnt != '0) begin
      if (!in_frag) begin
        left_cnt = left_cnt - 1'b1;
        emit(d, 1'b0, left_cnt == '0);
        if (left_cnt == '0) close_single(held);
      end else begin
        if (fill_cnt == '0) begin
          emit((held & h264fu_pkg::NAL_FNRI_MASK) | h264fu_pkg::FU_A_TYPE, 1'b1, 1'b0);
          fu = held & h264fu_pkg::NAL_TYPE_MASK;
          if (first_frag) fu |= h264fu_pkg::FU_S_BIT;
          if (int'(left_cnt) <= eff) fu |= h264fu_pkg::FU_E_BIT;
          first_frag = 1'b0;
          emit(fu, 1'b0, 1'b0);
        end
        left_cnt = left_cnt - 1'b1;
        fill_cnt = fill_cnt + 1'b1;
        close = (left_cnt == '0) || (int'(fill_cnt) >= eff);
        emit(d, 1'b0, close);
        if (close) begin
          seq_no   = seq_no + 1'b1;
          fill_cnt = '0;
          if (left_cnt == '0) begin
            in_frag = 1'b0;
            ts_now  = ts_now + ts_step;
          end
        end
      end
    end
    if (fresh_q.size() != 0) begin
      tail      = fresh_q.pop_back();
      tail.last = 1'b1;
      fresh_q.push_back(tail);
    end
  endtask

  // predict on accepted requests and register writes, score accepted output bytes
  always @(posedge clk) begin : scoreboard
    pkt_byte_t got;
    pkt_byte_t want;
    if (rst_n && in_tvalid && in_tready) begin
      packetize_byte(in_tdata[7:0], in_tuser, in_tdata[23:8]);
      if (!cur_req.typed) begin
        while (fresh_q.size() != 0) pkt_byte_q.push_back(fresh_q.pop_front());
      end else if (cur_req.tcnt) begin
        pkt_byte_q.push_back(cur_req.want);
      end
    end
    if (rst_n && cfg_we) begin
      if (cfg_index == h264fu_pkg::REG_MAX_PAYLOAD)
        max_pay = cfg_data[h264fu_pkg::PAY_W-1:0];
      else if (cfg_index == h264fu_pkg::REG_TS_STEP)
        ts_step = cfg_data;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[7:0], out_tuser[0], out_tlast, out_tdata[23:8],
              out_tdata[55:24], out_tuser[1]};
      if (pkt_byte_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected byte: pay=%h first=%b final=%b seq=%h ts=%h last=%b",
                   got.pay, got.first, got.fin, got.seq, got.ts, got.last);
        mismatches++;
      end else begin
        want = pkt_byte_q.pop_front();
        if (got.pay !== want.pay || got.first !== want.first || got.fin !== want.fin ||
            got.seq !== want.seq || got.ts !== want.ts || got.last !== want.last) begin
          if (mismatches < 10) begin
            $display("exp: pay=%h first=%b final=%b seq=%h ts=%h last=%b",
                     want.pay, want.first, want.fin, want.seq, want.ts, want.last);
            $display("got: pay=%h first=%b final=%b seq=%h ts=%h last=%b",
                     got.pay, got.first, got.fin, got.seq, got.ts, got.last);
          end
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver
  rx_mode_t rx_mode = RX_RUNS;
  logic     rx_on   = 1'b0;
  int       rx_run  = 0;

  always @(negedge clk) begin
    case (rx_mode)
      RX_OPEN: out_tready = 1'b1;
      RX_COIN: out_tready = ($urandom_range(0, 3) != 0);
      default: begin
        if (rx_run == 0) begin
          rx_on  = ~rx_on;
          rx_run = rx_on ? int'($urandom_range(1, 20)) : int'($urandom_range(1, 6));
        end
        rx_run--;
        out_tready = rx_on;
      end
    endcase
  end

  // ---------------------------------------------------------------- sender
  int burst_left = 0;
  bit tx_smooth  = 1'b0;

  task automatic send_byte(input nal_req_t req);
    int gap;
    if (burst_left == 0) begin
      burst_left = int'($urandom_range(1, 16));
      gap = tx_smooth ? 0 : int'($urandom_range(0, 5));
      if (gap != 0) begin
        @(negedge clk);
        in_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = {req.len, req.d};
    in_tuser  = req.st;
    cur_req   = req;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_nal(input logic [7:0] hdr,
                          input logic [h264fu_pkg::NAL_LEN_W-1:0] len,
                          input int body);
    nal_req_t req;
    req     = '0;
    req.d   = hdr;
    req.st  = 1'b1;
    req.len = len;
    send_byte(req);
    req.st = 1'b0;
    repeat (body) begin
      req.d   = 8'($urandom_range(0, 255));
      req.len = h264fu_pkg::NAL_LEN_W'($urandom_range(0, 65535));
      send_byte(req);
    end
  endtask

  // idle the input and let the block settle before touching registers
  task automatic drain();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pkt_byte_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [h264fu_pkg::CFG_IDX_W-1:0] idx,
                           input logic [h264fu_pkg::CFG_DATA_W-1:0] val);
    drain();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic dir_row_t row_byte(input logic [7:0] d, input logic st,
                                        input logic [h264fu_pkg::NAL_LEN_W-1:0] len);
    dir_row_t r;
    r         = '0;
    r.req.d   = d;
    r.req.st  = st;
    r.req.len = len;
    return r;
  endfunction

  // single-byte NAL whose output is obvious from the current sequence/timestamp
  function automatic dir_row_t row_chk(input logic [7:0] d,
                                       input logic [h264fu_pkg::NAL_LEN_W-1:0] len,
                                       input logic [h264fu_pkg::SEQ_W-1:0] seq,
                                       input logic [h264fu_pkg::TS_W-1:0] ts);
    dir_row_t r;
    r           = row_byte(d, 1'b1, len);
    r.req.typed = 1'b1;
    r.req.tcnt  = 1'b1;
    r.req.want  = '{d, 1'b1, 1'b1, seq, ts, 1'b1};
    return r;
  endfunction

  function automatic dir_row_t row_stray(input logic [7:0] d);
    dir_row_t r;
    r           = row_byte(d, 1'b0, 16'h0000);
    r.req.typed = 1'b1;
    return r;
  endfunction

  function automatic dir_row_t row_cfg(input logic [h264fu_pkg::CFG_IDX_W-1:0] idx,
                                       input logic [h264fu_pkg::CFG_DATA_W-1:0] val);
    dir_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    return r;
  endfunction

  function automatic logic [7:0] random_hdr();
    logic [7:0] h;
    h = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 4) == 0)
      h[4:0] = $urandom_range(0, 1) ? h264fu_pkg::NAL_TYPE_SPS[4:0] :
                                      h264fu_pkg::NAL_TYPE_PPS[4:0];
    return h;
  endfunction

  initial begin
    dir_row_t                          rows[$];
    nal_req_t                          noise;
    logic [h264fu_pkg::CFG_DATA_W-1:0] mp;
    logic [h264fu_pkg::CFG_DATA_W-1:0] step;
    int                                eff;
    int                                hi;
    int                                len;
    int                                body;
    int                                sent;
    int                                pick;

    max_pay    = h264fu_pkg::MAX_PAYLOAD_RST;
    ts_step    = h264fu_pkg::TS_STEP_RST;
    in_frag    = 1'b0;
    held       = '0;
    left_cnt   = '0;
    fill_cnt   = '0;
    first_frag = 1'b0;
    seq_no     = '0;
    ts_now     = '0;

    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // reset values, parameter sets hold the timestamp, zero length, stray byte
    rows.push_back(row_chk(8'h65, 16'd1, 16'd0, 32'd0));
    rows.push_back(row_chk(8'h67, 16'd1, 16'd1, 32'd3600));
    rows.push_back(row_chk(8'h68, 16'd0, 16'd2, 32'd3600));
    rows.push_back(row_stray(8'h12));
    rows.push_back(row_chk(8'hFF, 16'd1, 16'd3, 32'd3600));
    rows.push_back(row_chk(8'h00, 16'd1, 16'd4, 32'd7200));
    // payload size below range acts as the minimum; timestamp wraps
    rows.push_back(row_cfg(h264fu_pkg::REG_MAX_PAYLOAD, 32'hFFFF_E000));
    rows.push_back(row_cfg(h264fu_pkg::REG_TS_STEP, 32'hFFFF_FFFF));
    // F bit set, two fragments
    rows.push_back(row_byte(8'hE5, 1'b1, 16'd6));
    rows.push_back(row_byte(8'hA5, 1'b0, 16'd0));
    rows.push_back(row_byte(8'h5A, 1'b0, 16'd0));
    rows.push_back(row_byte(8'hFF, 1'b0, 16'd0));
    rows.push_back(row_byte(8'h00, 1'b0, 16'd0));
    rows.push_back(row_byte(8'h3C, 1'b0, 16'hFFFF));
    // sole fragment: S and E together
    rows.push_back(row_byte(8'h06, 1'b1, 16'd4));
    rows.push_back(row_byte(8'h11, 1'b0, 16'd0));
    rows.push_back(row_byte(8'h22, 1'b0, 16'd0));
    rows.push_back(row_byte(8'h33, 1'b0, 16'd0));
    // longest NAL, abandoned by the next header
    rows.push_back(row_byte(8'h45, 1'b1, 16'hFFFF));
    rows.push_back(row_byte(8'h80, 1'b0, 16'd0));
    rows.push_back(row_byte(8'h7F, 1'b0, 16'd0));
    rows.push_back(row_cfg(h264fu_pkg::REG_MAX_PAYLOAD, 32'd5));
    rows.push_back(row_byte(8'h21, 1'b1, 16'd10));
    repeat (4) rows.push_back(row_byte(8'hC3, 1'b0, 16'd0));
    // shrink below the open fragment's fill: it ends with the next byte
    rows.push_back(row_cfg(h264fu_pkg::REG_MAX_PAYLOAD, 32'd3));
    repeat (5) rows.push_back(row_byte(8'h96, 1'b0, 16'd0));

    rx_mode = RX_RUNS;
    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_reg(rows[i].idx, rows[i].val);
      else send_byte(rows[i].req);
    end

    for (int p = 0; p < 9; p++) begin
      rx_mode   = rx_mode_t'($urandom_range(0, 2));
      tx_smooth = ($urandom_range(0, 3) == 0);
      case (p % 4)
        0:       mp = $urandom_range(3, 12);
        1:       mp = $urandom_range(0, 2);
        2:       mp = $urandom_range(13, 24);
        default: mp = $urandom;
      endcase
      if (p == 8) mp = 32'hFFFF_FFFF;
      case (p % 3)
        0:       step = 32'd0;
        1:       step = 32'hFFFF_FFFF;
        default: step = $urandom;
      endcase
      write_reg(h264fu_pkg::REG_MAX_PAYLOAD, mp);
      write_reg(h264fu_pkg::REG_TS_STEP, step);
      eff = int'(mp[h264fu_pkg::PAY_W-1:0]);
      if (eff < int'(h264fu_pkg::PAYLOAD_MIN)) eff = int'(h264fu_pkg::PAYLOAD_MIN);
      if (eff > int'(h264fu_pkg::PAYLOAD_MAX)) eff = int'(h264fu_pkg::PAYLOAD_MAX);
      hi = eff * 3 + 2;
      if (hi > 32) hi = 32;

      sent = 0;
      while (sent < 12) begin
        pick = int'($urandom_range(0, 9));
        if (pick < 8) begin
          len = int'($urandom_range(1, hi));
          if ($urandom_range(0, 15) == 0) len = 0;
          body = (len == 0) ? 0 : len - 1;
          send_nal(random_hdr(), h264fu_pkg::NAL_LEN_W'(len), body);
          sent += body + 1;
        end else if (pick == 8) begin
          body = int'($urandom_range(0, 3));
          send_nal(random_hdr(), h264fu_pkg::NAL_LEN_W'($urandom_range(0, 65535)), body);
          sent += body + 1;
        end else begin
          noise     = '0;
          noise.len = h264fu_pkg::NAL_LEN_W'($urandom_range(0, 65535));
          repeat ($urandom_range(1, 3)) begin
            noise.d = 8'($urandom_range(0, 255));
            send_byte(noise);
          end
        end
      end
    end

    drain();
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

[sim.f]
src/h264fu_pkg.sv
src/h264fu_step.sv
src/h264_rtp_fu_a_packetizer.sv
src/h264fu_chk.sv
dv/h264_rtp_fu_a_packetizer_test.sv
